// ----- src/rtc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared types, constants and the box overlap function of the range counter.
// ----------------------------------------------------------------------------
package rtc_pkg;

	localparam int TOP_ENTRIES    = 256;
	localparam int LEAF_NODES     = 256;
	localparam int RECTS_PER_LEAF = 64;
	localparam int COORD_WIDTH    = 32;

	localparam int TOP_AW   = $clog2(TOP_ENTRIES);
	localparam int NODE_AW  = $clog2(LEAF_NODES);
	localparam int RECT_AW  = $clog2(RECTS_PER_LEAF);
	localparam int ENTRY_AW = NODE_AW + RECT_AW;
	localparam int TOTAL_W  = $clog2(RECTS_PER_LEAF + 1);
	localparam int CNT_W    = 9;
	localparam int HIT_W    = 15;
	localparam logic [HIT_W-1:0] HIT_MAX = {HIT_W{1'b1}};

	localparam logic [1:0] OP_LOAD_TOP  = 2'd0;
	localparam logic [1:0] OP_LOAD_NODE = 2'd1;
	localparam logic [1:0] OP_LOAD_RECT = 2'd2;
	localparam logic [1:0] OP_QUERY     = 2'd3;

	localparam logic [2:0] REG_TOP_COUNT  = 3'd0;
	localparam logic [2:0] REG_LEAF_COUNT = 3'd1;
	localparam logic [2:0] REG_WIN_FIRST  = 3'd2;
	localparam logic [2:0] REG_WIN_SPAN   = 3'd3;
	localparam logic [2:0] REG_SPARSE     = 3'd4;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] lx;
		logic signed [COORD_WIDTH-1:0] ly;
		logic signed [COORD_WIDTH-1:0] hx;
		logic signed [COORD_WIDTH-1:0] hy;
	} box_t;

	typedef struct packed {
		logic [15:0] tag;
		box_t        box;
	} query_t;

	typedef struct packed {
		logic [CNT_W-1:0] top_count;
		logic [CNT_W-1:0] leaf_count;
		logic [7:0]       win_first;
		logic [CNT_W-1:0] win_span;
		logic             sparse;
	} cfg_t;

	function automatic logic boxes_meet(box_t a, box_t b);
		return !(a.hx < b.lx || a.lx > b.hx || a.hy < b.ly || a.ly > b.hy);
	endfunction

endpackage
`default_nettype wire

// ----- src/rtc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_front
// Accepts items, performs table loads and queues queries for the search.
// ----------------------------------------------------------------------------
module rtc_front (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [1:0]              operation,
	input  wire logic [7:0]              slot,
	input  wire logic [5:0]              rect_slot,
	input  wire logic                    leaf_flag,
	input  wire logic [15:0]             rect_total,
	input  wire rtc_pkg::box_t           in_box,
	input  wire logic [15:0]             query_tag,
	output logic                         top_we,
	output logic                         node_we,
	output logic                         rect_we,
	output logic [rtc_pkg::TOTAL_W-1:0]  total_clamped,
	output logic                         q_valid,
	output rtc_pkg::query_t              q_data,
	input  wire logic                    q_pop,
	input  wire logic                    search_busy
);
	rtc_pkg::query_t          fifo_q [rtc_pkg::QDEPTH];
	logic [rtc_pkg::QAW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [rtc_pkg::QAW:0]    fill_q;
	logic                     take, push;

	// A load must not change the tables under a query that is still queued
	// or being searched, so loads wait until the back part has drained.
	assign busy = (fill_q == (rtc_pkg::QAW+1)'(rtc_pkg::QDEPTH))
	              || ((operation != rtc_pkg::OP_QUERY) && (q_valid || search_busy));
	assign take = start && !busy;
	assign push = take && (operation == rtc_pkg::OP_QUERY);

	assign top_we  = take && (operation == rtc_pkg::OP_LOAD_TOP)
	                 && ({1'b0, slot} < 9'(rtc_pkg::TOP_ENTRIES));
	assign node_we = take && (operation == rtc_pkg::OP_LOAD_NODE)
	                 && ({1'b0, slot} < 9'(rtc_pkg::LEAF_NODES));
	assign rect_we = take && (operation == rtc_pkg::OP_LOAD_RECT)
	                 && ({1'b0, slot} < 9'(rtc_pkg::LEAF_NODES))
	                 && ({1'b0, rect_slot} < 7'(rtc_pkg::RECTS_PER_LEAF));
	assign total_clamped = (rect_total > 16'(rtc_pkg::RECTS_PER_LEAF))
	                       ? rtc_pkg::TOTAL_W'(rtc_pkg::RECTS_PER_LEAF)
	                       : rect_total[rtc_pkg::TOTAL_W-1:0];

	assign q_valid = (fill_q != '0);
	assign q_data  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{tag: query_tag, box: in_box};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			fill_q <= fill_q + (push ? 1'b1 : 1'b0) - (q_pop ? 1'b1 : 1'b0);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty query queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> fill_q == $past(fill_q) + 1'b1)
		else $error("queue fill lost a push");
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (rtc_pkg::QAW+1)'(rtc_pkg::QDEPTH))
		else $error("queue overfilled");
endmodule
`default_nettype wire

// ----- src/rtc_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_back
// Holds the three tables and walks a query: window, node headers, rectangles.
// ----------------------------------------------------------------------------
module rtc_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire rtc_pkg::cfg_t              cfg,
	input  wire logic                       top_we,
	input  wire logic                       node_we,
	input  wire logic                       rect_we,
	input  wire logic [7:0]                 slot,
	input  wire logic [5:0]                 rect_slot,
	input  wire logic                       leaf_flag,
	input  wire logic [rtc_pkg::TOTAL_W-1:0] total_clamped,
	input  wire rtc_pkg::box_t              in_box,
	input  wire logic                       q_valid,
	input  wire rtc_pkg::query_t            q_data,
	output logic                            q_pop,
	output logic                            search_busy,
	output logic                            result_valid,
	output logic [15:0]                     result_tag,
	output logic [14:0]                     hit_count
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TOP  = 3'd1;
	localparam logic [2:0] ST_NODE = 3'd2;
	localparam logic [2:0] ST_RECT = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	rtc_pkg::box_t top_mem  [rtc_pkg::TOP_ENTRIES];
	logic [rtc_pkg::TOTAL_W:0] node_hdr_mem [rtc_pkg::LEAF_NODES];
	rtc_pkg::box_t node_mem [rtc_pkg::LEAF_NODES];
	rtc_pkg::box_t rect_mem [rtc_pkg::LEAF_NODES*rtc_pkg::RECTS_PER_LEAF];

	logic [2:0]                  state_q;
	rtc_pkg::query_t             qry_q;
	logic [rtc_pkg::CNT_W-1:0]   idx_q, end_q;
	logic [rtc_pkg::RECT_AW:0]   k_q;
	logic [rtc_pkg::TOTAL_W-1:0] total_q;
	logic [rtc_pkg::HIT_W-1:0]   hits_q;
	logic                        rd_ok_q;
	rtc_pkg::box_t               top_rd_q, node_rd_q, rect_rd_q;
	logic [rtc_pkg::TOTAL_W:0]   hdr_rd_q;

	logic [rtc_pkg::CNT_W:0] win_e_full;
	logic [rtc_pkg::CNT_W-1:0] win_s, win_e;
	logic [rtc_pkg::ENTRY_AW-1:0] rect_addr;

	always_comb begin
		win_e_full = {2'b0, cfg.win_first} + {1'b0, cfg.win_span};
		win_s = (cfg.win_first == '0) ? 9'd1 : {1'b0, cfg.win_first};
		win_e = (win_e_full > {1'b0, cfg.top_count}) ? cfg.top_count
		        : win_e_full[rtc_pkg::CNT_W-1:0];
		if (win_s >= win_e) begin
			win_s = 9'd1;
			win_e = cfg.top_count;
		end
	end

	assign rect_addr = {idx_q[rtc_pkg::NODE_AW-1:0], k_q[rtc_pkg::RECT_AW-1:0]};

	always_ff @(posedge clk) begin
		if (top_we) top_mem[slot] <= in_box;
		if (node_we) begin
			node_mem[slot]     <= in_box;
			node_hdr_mem[slot] <= {leaf_flag, total_clamped};
		end
		if (rect_we) rect_mem[{slot, rect_slot}] <= in_box;
		top_rd_q  <= top_mem[idx_q[rtc_pkg::TOP_AW-1:0]];
		node_rd_q <= node_mem[idx_q[rtc_pkg::NODE_AW-1:0]];
		hdr_rd_q  <= node_hdr_mem[idx_q[rtc_pkg::NODE_AW-1:0]];
		rect_rd_q <= rect_mem[rect_addr];
	end

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign search_busy = (state_q != ST_IDLE);

	// rd_ok_q marks that the registered read data belongs to the current index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rd_ok_q      <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						qry_q   <= q_data;
						hits_q  <= '0;
						idx_q   <= win_s;
						end_q   <= win_e;
						rd_ok_q <= 1'b0;
						if (cfg.leaf_count == '0 || win_s >= win_e) state_q <= ST_DONE;
						else state_q <= ST_TOP;
					end
				end
				ST_TOP: begin
					if (!rd_ok_q) rd_ok_q <= 1'b1;
					else if (rtc_pkg::boxes_meet(top_rd_q, qry_q.box)) begin
						idx_q <= '0; rd_ok_q <= 1'b0; state_q <= ST_NODE;
					end else if (idx_q + 1'b1 >= end_q) state_q <= ST_DONE;
					else begin
						idx_q <= idx_q + 1'b1; rd_ok_q <= 1'b0;
					end
				end
				ST_NODE: begin
					if (!rd_ok_q) rd_ok_q <= 1'b1;
					else if (rtc_pkg::boxes_meet(node_rd_q, qry_q.box)
					         && hdr_rd_q[rtc_pkg::TOTAL_W]
					         && hdr_rd_q[rtc_pkg::TOTAL_W-1:0] != '0) begin
						total_q <= hdr_rd_q[rtc_pkg::TOTAL_W-1:0];
						k_q <= '0; rd_ok_q <= 1'b0; state_q <= ST_RECT;
					end else if (idx_q + 1'b1 >= cfg.leaf_count) state_q <= ST_DONE;
					else begin
						idx_q <= idx_q + 1'b1; rd_ok_q <= 1'b0;
					end
				end
				ST_RECT: begin
					if (!rd_ok_q) rd_ok_q <= 1'b1;
					else begin
						if (rtc_pkg::boxes_meet(rect_rd_q, qry_q.box)
						    && hits_q != rtc_pkg::HIT_MAX)
							hits_q <= hits_q + 1'b1;
						rd_ok_q <= 1'b0;
						if (k_q + 1'b1 >= (rtc_pkg::RECT_AW+1)'(total_q)) begin
							if (idx_q + 1'b1 >= cfg.leaf_count) state_q <= ST_DONE;
							else begin
								idx_q <= idx_q + 1'b1; state_q <= ST_NODE;
							end
						end else k_q <= k_q + 1'b1;
					end
				end
				ST_DONE: begin
					result_valid <= !(cfg.sparse && hits_q == '0);
					result_tag   <= qry_q.tag;
					hit_count    <= hits_q;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q) == ST_DONE)
		else $error("result without finished search");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RECT) |-> k_q < (rtc_pkg::RECT_AW+1)'(rtc_pkg::RECTS_PER_LEAF))
		else $error("rectangle index beyond leaf");
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q != ST_IDLE)
		else $error("popped query not started");
endmodule
`default_nettype wire

// ----- src/rtree_two_level_range_count.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtree_two_level_range_count
// Counts stored rectangles overlapping a query box in a two-level R-tree shard.
// ----------------------------------------------------------------------------
// Search order: a query walks the upper entries, node headers and rectangles that
// it visits; each is read from its table into a register and then compared.
// A query may also wait in the queue before its search begins.
// Throughput: one query is searched at a time and up to four more queue; a load
// is held off while any query is queued or searched. The receiver cannot stall
// and a result is shown for one cycle. Reset clears registers, not the tables.
module rtree_two_level_range_count (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [8:0]  cfg_data,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  slot,
	input  wire logic [5:0]  rect_slot,
	input  wire logic        leaf_flag,
	input  wire logic [15:0] rect_total,
	input  wire logic signed [31:0] lo_x,
	input  wire logic signed [31:0] lo_y,
	input  wire logic signed [31:0] hi_x,
	input  wire logic signed [31:0] hi_y,
	input  wire logic [15:0] query_tag,
	output logic             result_valid,
	output logic [15:0]      result_tag,
	output logic [14:0]      hit_count
);
	rtc_pkg::cfg_t   cfg_q;
	rtc_pkg::box_t   in_box;
	rtc_pkg::query_t q_data;
	logic top_we, node_we, rect_we, q_valid, q_pop, search_busy;
	logic [rtc_pkg::TOTAL_W-1:0] total_clamped;

	assign in_box = '{lx: lo_x, ly: lo_y, hx: hi_x, hy: hi_y};

	// Count registers saturate at the table sizes when written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.top_count  <= 9'(rtc_pkg::TOP_ENTRIES);
			cfg_q.leaf_count <= '0;
			cfg_q.win_first  <= 8'd1;
			cfg_q.win_span   <= '0;
			cfg_q.sparse     <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rtc_pkg::REG_TOP_COUNT: cfg_q.top_count <=
					(cfg_data > 9'(rtc_pkg::TOP_ENTRIES)) ? 9'(rtc_pkg::TOP_ENTRIES) : cfg_data;
				rtc_pkg::REG_LEAF_COUNT: cfg_q.leaf_count <=
					(cfg_data > 9'(rtc_pkg::LEAF_NODES)) ? 9'(rtc_pkg::LEAF_NODES) : cfg_data;
				rtc_pkg::REG_WIN_FIRST: cfg_q.win_first <= cfg_data[7:0];
				rtc_pkg::REG_WIN_SPAN:  cfg_q.win_span  <= cfg_data;
				rtc_pkg::REG_SPARSE:    cfg_q.sparse    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	rtc_front u_front (
		.clk, .arst_n, .start, .busy, .operation, .slot, .rect_slot, .leaf_flag,
		.rect_total, .in_box, .query_tag, .top_we, .node_we, .rect_we,
		.total_clamped, .q_valid, .q_data, .q_pop, .search_busy
	);

	rtc_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .top_we, .node_we, .rect_we, .slot, .rect_slot,
		.leaf_flag, .total_clamped, .in_box, .q_valid, .q_data, .q_pop,
		.search_busy, .result_valid, .result_tag, .hit_count
	);
endmodule
`default_nettype wire
